[design/swpm_pkg.sv]
package swpm_pkg;

    // sample and frame geometry
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_DIM     = 4096;

    localparam int PAT_W   = 8;
    localparam int COMP_W  = 16;
    localparam int DIM_W   = $clog2(MAX_DIM);       // column / row counters
    localparam int DIMC_W  = $clog2(MAX_DIM + 1);   // clamped frame size
    localparam int CNT_W   = 4;                     // neighbour pass count, 0..9
    localparam int WGT_W   = SAMPLE_BITS + 1;       // blend weight, 0..2^SAMPLE_BITS
    localparam int DIFF_W  = COMP_W + 1;
    localparam int PROD_W  = DIFF_W + WGT_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam longint unsigned ONE = 64'd1 << SAMPLE_BITS;
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(ONE);
    localparam logic [COMP_W-1:0] SMASK = COMP_W'(ONE - 64'd1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANTIALIAS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

    // neighbourhood size codes
    localparam logic [1:0] TOT_FOUR = 2'd0;
    localparam logic [1:0] TOT_SIX  = 2'd1;
    localparam logic [1:0] TOT_NINE = 2'd2;

    typedef struct packed {
        logic [PAT_W-1:0]  threshold;
        logic              direction;
        logic              antialias;
        logic              has_alpha;
        logic [DIMC_W-1:0] width;
        logic [DIMC_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [COMP_W-1:0] c3;
        logic [COMP_W-1:0] c2;
        logic [COMP_W-1:0] c1;
        logic [COMP_W-1:0] c0;
    } pix_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [1:0]       tsel;
        logic             cpass;
    } job_t;

    // one queue entry: previous pixel, plus the current one at row end
    typedef struct packed {
        logic two;
        job_t j0;
        job_t j1;
        pix_t in0;
        pix_t out0;
        pix_t in1;
        pix_t out1;
    } bundle_t;

    // round(count * 2^SAMPLE_BITS / total)
    function automatic logic [WGT_W-1:0] weight_of(input logic [CNT_W-1:0] cnt,
                                                   input logic [1:0] tsel);
        logic [WGT_W-1:0] w;
        w = '0;
        case (tsel)
            TOT_FOUR:
            begin
                case (cnt)
                    4'd1: w = WGT_W'((2 * 1 * ONE + 4) / 8);
                    4'd2: w = WGT_W'((2 * 2 * ONE + 4) / 8);
                    4'd3: w = WGT_W'((2 * 3 * ONE + 4) / 8);
                    4'd4: w = WGT_W'((2 * 4 * ONE + 4) / 8);
                    default: w = '0;
                endcase
            end
            TOT_SIX:
            begin
                case (cnt)
                    4'd1: w = WGT_W'((2 * 1 * ONE + 6) / 12);
                    4'd2: w = WGT_W'((2 * 2 * ONE + 6) / 12);
                    4'd3: w = WGT_W'((2 * 3 * ONE + 6) / 12);
                    4'd4: w = WGT_W'((2 * 4 * ONE + 6) / 12);
                    4'd5: w = WGT_W'((2 * 5 * ONE + 6) / 12);
                    4'd6: w = WGT_W'((2 * 6 * ONE + 6) / 12);
                    default: w = '0;
                endcase
            end
            TOT_NINE:
            begin
                case (cnt)
                    4'd1: w = WGT_W'((2 * 1 * ONE + 9) / 18);
                    4'd2: w = WGT_W'((2 * 2 * ONE + 9) / 18);
                    4'd3: w = WGT_W'((2 * 3 * ONE + 9) / 18);
                    4'd4: w = WGT_W'((2 * 4 * ONE + 9) / 18);
                    4'd5: w = WGT_W'((2 * 5 * ONE + 9) / 18);
                    4'd6: w = WGT_W'((2 * 6 * ONE + 9) / 18);
                    4'd7: w = WGT_W'((2 * 7 * ONE + 9) / 18);
                    4'd8: w = WGT_W'((2 * 8 * ONE + 9) / 18);
                    4'd9: w = WGT_W'((2 * 9 * ONE + 9) / 18);
                    default: w = '0;
                endcase
            end
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

[design/swpm_front.sv]
module swpm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  swpm_pkg::cfg_t    cfg,
    input  logic              accept,
    input  logic [7:0]        pat_above,
    input  logic [7:0]        pat_centre,
    input  logic [7:0]        pat_below,
    input  swpm_pkg::pix_t    pix_in,
    input  swpm_pkg::pix_t    pix_out,
    output logic              push,
    output swpm_pkg::bundle_t bundle
);
    import swpm_pkg::*;

    localparam int CW = DIMC_W + 1;

    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [PAT_W-1:0] win_left_reg [3];
    logic [PAT_W-1:0] win_mid_reg [3];
    pix_t             held_in_reg, held_out_reg;

    logic [CW-1:0] width_x, height_x;
    logic [CW-1:0] col_x, row_x, row_step, col_cur, row_cur, col_inc, row_inc;
    logic          col_wrap, top, bottom, left_ok;
    logic [1:0]    cnt_left, cnt_mid, cnt_cur;
    pix_t          in_m, out_m;

    function automatic logic passes(input logic [PAT_W-1:0] v, input cfg_t c);
        return c.direction ? (v <= c.threshold) : (v >= c.threshold);
    endfunction

    // passing values in one pattern column, rows outside the frame left out
    function automatic logic [1:0] col_pass(input logic [PAT_W-1:0] a, input logic [PAT_W-1:0] m,
                                            input logic [PAT_W-1:0] b, input logic is_top,
                                            input logic is_bottom, input cfg_t c);
        return 2'(passes(a, c) && !is_top) + 2'(passes(m, c)) + 2'(passes(b, c) && !is_bottom);
    endfunction

    always_comb
    begin
        width_x  = CW'(cfg.width);
        height_x = CW'(cfg.height);
        col_x    = CW'(col_reg);
        row_x    = CW'(row_reg);

        // a size change mid-frame can leave the counters out of range
        col_wrap = col_x >= width_x;
        row_step = col_wrap ? row_x + CW'(1) : row_x;
        row_cur  = (row_step >= height_x) ? '0 : row_step;
        col_cur  = col_wrap ? '0 : col_x;
        top      = row_cur == '0;
        bottom   = row_cur == height_x - CW'(1);
        left_ok  = col_cur >= CW'(2);

        col_inc = col_cur + CW'(1);
        row_inc = row_cur + CW'(1);
        if (col_inc >= width_x)
        begin
            col_next = '0;
            row_next = (row_inc >= height_x) ? '0 : row_inc[DIM_W-1:0];
        end
        else
        begin
            col_next = col_inc[DIM_W-1:0];
            row_next = row_cur[DIM_W-1:0];
        end

        in_m.c0  = pix_in.c0 & SMASK;
        in_m.c1  = pix_in.c1 & SMASK;
        in_m.c2  = pix_in.c2 & SMASK;
        in_m.c3  = pix_in.c3 & SMASK;
        out_m.c0 = pix_out.c0 & SMASK;
        out_m.c1 = pix_out.c1 & SMASK;
        out_m.c2 = pix_out.c2 & SMASK;
        out_m.c3 = pix_out.c3 & SMASK;

        cnt_left = col_pass(win_left_reg[0], win_left_reg[1], win_left_reg[2], top, bottom, cfg);
        cnt_mid  = col_pass(win_mid_reg[0], win_mid_reg[1], win_mid_reg[2], top, bottom, cfg);
        cnt_cur  = col_pass(pat_above, pat_centre, pat_below, top, bottom, cfg);

        bundle.two = col_cur == width_x - CW'(1);

        bundle.j0.count = (left_ok ? CNT_W'(cnt_left) : '0) + CNT_W'(cnt_mid) + CNT_W'(cnt_cur);
        if (left_ok && !top && !bottom)
            bundle.j0.tsel = TOT_NINE;
        else if (left_ok || (!top && !bottom))
            bundle.j0.tsel = TOT_SIX;
        else
            bundle.j0.tsel = TOT_FOUR;
        bundle.j0.cpass = passes(win_mid_reg[1], cfg);

        bundle.j1.count = CNT_W'(cnt_mid) + CNT_W'(cnt_cur);
        bundle.j1.tsel  = (!top && !bottom) ? TOT_SIX : TOT_FOUR;
        bundle.j1.cpass = passes(pat_centre, cfg);

        bundle.in0  = held_in_reg;
        bundle.out0 = held_out_reg;
        bundle.in1  = in_m;
        bundle.out1 = out_m;

        // the first pixel of a row releases nothing
        push = accept && (col_cur != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_left_reg <= win_mid_reg;
            win_mid_reg  <= '{pat_above, pat_centre, pat_below};
            held_in_reg  <= in_m;
            held_out_reg <= out_m;
        end
    end

endmodule

[design/swpm_fifo.sv]
module swpm_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  swpm_pkg::bundle_t wdata,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output swpm_pkg::bundle_t rdata
);
    import swpm_pkg::*;

    bundle_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full  = cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign valid = cnt_reg != '0;
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

[design/swpm_back.sv]
module swpm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  swpm_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  swpm_pkg::bundle_t head,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_ready,
    output swpm_pkg::pix_t    res_pix,
    output logic              res_last
);
    import swpm_pkg::*;

    logic sel_reg;

    // stage a: weight and differences
    logic                     va_reg;
    logic [WGT_W-1:0]         wgt_a_reg;
    logic signed [DIFF_W-1:0] diff_a_reg [3];
    logic [COMP_W-1:0]        base_a_reg [3];
    logic [COMP_W-1:0]        alpha_a_reg;
    logic                     last_a_reg;

    // stage b: products
    logic                     vb_reg;
    logic signed [PROD_W-1:0] prod_b_reg [3];
    logic [COMP_W-1:0]        base_b_reg [3];
    logic [COMP_W-1:0]        alpha_b_reg;
    logic                     last_b_reg;

    // stage c: output register
    logic                     vc_reg;
    pix_t                     mix_reg;
    logic                     last_reg;

    logic              adv_a, adv_b, adv_c, issue;
    job_t              job;
    pix_t              pin, pout;
    logic [WGT_W-1:0]  wgt;
    logic [COMP_W-1:0] alpha;
    logic [COMP_W-1:0] in_arr [3];
    logic [COMP_W-1:0] out_arr [3];
    logic signed [PROD_W-1:0] sum [3];

    assign adv_c = !vc_reg || res_ready;
    assign adv_b = !vb_reg || adv_c;
    assign adv_a = !va_reg || adv_b;
    assign issue = q_valid && adv_a;
    assign pop   = issue && (sel_reg || !head.two);

    always_comb
    begin
        job  = sel_reg ? head.j1 : head.j0;
        pin  = sel_reg ? head.in1 : head.in0;
        pout = sel_reg ? head.out1 : head.out0;

        // hard switch is a blend with a full or empty weight
        if (cfg.antialias)
            wgt = weight_of(job.count, job.tsel);
        else
            wgt = job.cpass ? WGT_ONE : '0;

        if (!cfg.has_alpha)
            alpha = '0;
        else if (!cfg.antialias && job.cpass)
            alpha = pin.c3;
        else
            alpha = pout.c3;

        in_arr  = '{pin.c0, pin.c1, pin.c2};
        out_arr = '{pout.c0, pout.c1, pout.c2};

        // out + floor((in - out) * wgt / 2^SAMPLE_BITS)
        for (int i = 0; i < 3; i++)
            sum[i] = $signed({{(PROD_W - COMP_W){1'b0}}, base_b_reg[i]})
                     + (prod_b_reg[i] >>> SAMPLE_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            vc_reg  <= 1'b0;
        end
        else
        begin
            if (issue)
                sel_reg <= !sel_reg && head.two;
            if (adv_a)
                va_reg <= q_valid;
            if (adv_b)
                vb_reg <= va_reg;
            if (adv_c)
                vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            wgt_a_reg   <= wgt;
            alpha_a_reg <= alpha;
            last_a_reg  <= sel_reg || !head.two;
            for (int i = 0; i < 3; i++)
            begin
                diff_a_reg[i] <= $signed({1'b0, in_arr[i]}) - $signed({1'b0, out_arr[i]});
                base_a_reg[i] <= out_arr[i];
            end
        end
        if (adv_b && va_reg)
        begin
            alpha_b_reg <= alpha_a_reg;
            last_b_reg  <= last_a_reg;
            for (int i = 0; i < 3; i++)
            begin
                prod_b_reg[i] <= PROD_W'(diff_a_reg[i] * $signed({1'b0, wgt_a_reg}));
                base_b_reg[i] <= base_a_reg[i];
            end
        end
        if (adv_c && vb_reg)
        begin
            mix_reg.c0 <= sum[0][COMP_W-1:0];
            mix_reg.c1 <= sum[1][COMP_W-1:0];
            mix_reg.c2 <= sum[2][COMP_W-1:0];
            mix_reg.c3 <= alpha_b_reg;
            last_reg   <= last_b_reg;
        end
    end

    assign res_valid = vc_reg;
    assign res_pix   = mix_reg;
    assign res_last  = last_reg;

endmodule

[design/shape_wipe_pixel_mixer_unit.sv]
// output: m_tvalid rises once a released word has passed the queue, stage a, stage b and the
// output register; the releasing item is the next pixel of the row, and at a row end the
// pixel's own word follows the released one; throughput: one pixel per cycle while the queue
// is not full; a row end issues two words to the back end, which the first pixel of the next
// row repays by releasing nothing; the 4-deep queue absorbs output stalls
// reset: asynchronous, active low; clears counters, queue and pipeline valids, loads defaults
module shape_wipe_pixel_mixer_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write port
    input  logic                                 cfg_we,
    input  logic [swpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swpm_pkg::CFG_DATA_W-1:0]      cfg_data,

    // input pixel stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pat_above, pat_centre, pat_below, in_c0, in_c1, in_c2, in_c3,
    // out_c0, out_c1, out_c2, out_c3
    input  logic [swpm_pkg::IN_TDATA_W-1:0]      s_tdata,

    // mixed pixel stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // mix_c0, mix_c1, mix_c2, mix_c3
    output logic [swpm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // last_in_run
    output logic                                 m_tlast
);
    import swpm_pkg::*;

    cfg_t    cfg_reg;
    logic    accept;
    logic    push, q_full, q_valid, pop;
    bundle_t push_bundle, head_bundle;
    pix_t    pix_in, pix_out, res_pix;

    // frame sizes are clamped once when written
    function automatic logic [DIMC_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIMC_W-1:0] r;
        if (v < CFG_DATA_W'(2))
            r = DIMC_W'(2);
        else if (32'(v) > MAX_DIM)
            r = DIMC_W'(MAX_DIM);
        else
            r = DIMC_W'(v);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= '0;
            cfg_reg.direction <= 1'b0;
            cfg_reg.antialias <= 1'b0;
            cfg_reg.has_alpha <= 1'b1;
            cfg_reg.width     <= DIMC_W'(2);
            cfg_reg.height    <= DIMC_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD:    cfg_reg.threshold <= cfg_data[PAT_W-1:0];
                REG_DIRECTION:    cfg_reg.direction <= cfg_data[0];
                REG_ANTIALIAS:    cfg_reg.antialias <= cfg_data[0];
                REG_HAS_ALPHA:    cfg_reg.has_alpha <= cfg_data[0];
                REG_FRAME_WIDTH:  cfg_reg.width     <= clamp_dim(cfg_data);
                REG_FRAME_HEIGHT: cfg_reg.height    <= clamp_dim(cfg_data);
                default:          ;
            endcase
        end
    end

    // front end only stalls on a full queue
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // unpack the input word, pattern column first
    assign pix_in.c0  = s_tdata[39:24];
    assign pix_in.c1  = s_tdata[55:40];
    assign pix_in.c2  = s_tdata[71:56];
    assign pix_in.c3  = s_tdata[87:72];
    assign pix_out.c0 = s_tdata[103:88];
    assign pix_out.c1 = s_tdata[119:104];
    assign pix_out.c2 = s_tdata[135:120];
    assign pix_out.c3 = s_tdata[151:136];

    // raster counters, pattern window and neighbour counts
    swpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .pat_above  (s_tdata[7:0]),
        .pat_centre (s_tdata[15:8]),
        .pat_below  (s_tdata[23:16]),
        .pix_in     (pix_in),
        .pix_out    (pix_out),
        .push       (push),
        .bundle     (push_bundle)
    );

    // decouples the pixel rate from the blend pipeline
    swpm_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_bundle),
        .full  (q_full),
        .pop   (pop),
        .valid (q_valid),
        .rdata (head_bundle)
    );

    // weight lookup, multiply, accumulate, output register
    swpm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .head      (head_bundle),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_pix   (res_pix),
        .res_last  (m_tlast)
    );

    assign m_tdata = {res_pix.c3, res_pix.c2, res_pix.c1, res_pix.c0};

endmodule

[design/swpm_checker.sv]
module swpm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_we,
    input logic [swpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input logic [swpm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [swpm_pkg::IN_TDATA_W-1:0]      s_tdata,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [swpm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input logic                                 m_tlast
);
    import swpm_pkg::*;

    logic has_alpha_reg;
    logic prev_last_reg;
    logic in_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_alpha_reg <= 1'b1;
            prev_last_reg <= 1'b1;
            in_seen_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_HAS_ALPHA)
                has_alpha_reg <= cfg_data[0];
            if (m_tvalid && m_tready)
                prev_last_reg <= m_tlast;
            if (s_tvalid && s_tready)
                in_seen_reg <= 1'b1;
        end
    end

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // a word that is not last in its run is always followed by the last one
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !prev_last_reg |-> m_tlast)
        else $error("two non-last words in a row");

    // alpha is zero without an alpha channel
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !has_alpha_reg |-> m_tdata[63:48] == '0)
        else $error("alpha set with alpha disabled");

    // no output word before any input word
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_seen_reg |-> !m_tvalid)
        else $error("output word with no input");

endmodule

bind shape_wipe_pixel_mixer_unit swpm_checker u_swpm_checker (.*);
